[hw/rtl/acps_pkg.sv]
// Package for the ATA PIO command sequencer.
// Holds result kinds, opcodes, the result and descriptor types. No dependencies.
package acps_pkg;

    localparam logic [2:0] OP_RESET   = 3'd0;
    localparam logic [2:0] OP_NODATA  = 3'd1;
    localparam logic [2:0] OP_PIOIN   = 3'd2;
    localparam logic [2:0] OP_PIOOUT  = 3'd3;
    localparam logic [2:0] OP_RESP    = 3'd4;
    localparam logic [2:0] OP_DATA    = 3'd5;

    localparam logic [2:0] KIND_RD    = 3'd0;
    localparam logic [2:0] KIND_WR    = 3'd1;
    localparam logic [2:0] KIND_HOST  = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_READY = 3'd4;

    localparam logic [1:0] MODE_NODATA = 2'd1;
    localparam logic [1:0] MODE_PIOIN  = 2'd2;

    localparam logic [7:0] ST_BSY   = 8'h80;
    localparam logic [7:0] ST_EMASK = 8'h21;
    localparam logic [7:0] ST_DRQ   = 8'h08;
    localparam logic [7:0] ST_ERR   = 8'h01;
    localparam logic [7:0] DRV_SLV  = 8'h10;
    localparam logic [7:0] CTL_SRST = 8'h04;
    localparam logic [7:0] NO_BUS   = 8'hFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic        blk;
        logic [2:0]  off;
        logic [15:0] data;
        logic        word;
        logic [7:0]  rc;
        logic        back;
    } res_t;

    typedef struct packed {
        logic        tf;
        logic        two;
        res_t        r0;
        res_t        r1;
        logic [39:0] rb;
        logic        ext;
        logic [7:0]  drive;
        logic [7:0]  cmd;
        logic [15:0] feat;
        logic [15:0] count;
        logic [15:0] sect;
        logic [15:0] cyll;
        logic [15:0] cylh;
    } desc_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic avail;
    } q_ctl_t;

    function automatic res_t mk_res(logic [2:0] kind, logic blk, logic [2:0] off,
                                    logic [15:0] data, logic word, logic [7:0] rc,
                                    logic back);
        res_t r;
        r.kind = kind;
        r.blk  = blk;
        r.off  = off;
        r.data = data;
        r.word = word;
        r.rc   = rc;
        r.back = back;
        return r;
    endfunction

endpackage

[hw/rtl/acps_front.sv]
// Front end of the ATA PIO command sequencer: protocol state and item classification.
// Depends on acps_pkg. Emits one result descriptor per item that causes results.
module acps_front
    import acps_pkg::*;
#(
    parameter int SETTLE = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic [2:0]   op,
    input  logic [151:0] din,
    output logic         push,
    output desc_t        desc
);

    localparam logic [4:0] SETTLE_N = 5'(SETTLE);

    typedef enum logic [13:0] {
        PH_IDLE       = 14'b00000000000001,
        PH_RST_FIRST  = 14'b00000000000010,
        PH_RST_SETTLE = 14'b00000000000100,
        PH_RST_CHECK  = 14'b00000000001000,
        PH_RST_POLL   = 14'b00000000010000,
        PH_CMD_BSY1   = 14'b00000000100000,
        PH_CMD_DRV    = 14'b00000001000000,
        PH_CMD_SEL    = 14'b00000010000000,
        PH_CMD_BSY2   = 14'b00000100000000,
        PH_READBACK   = 14'b00001000000000,
        PH_DPOLL      = 14'b00010000000000,
        PH_DIN        = 14'b00100000000000,
        PH_DOUT       = 14'b01000000000000,
        PH_FIN        = 14'b10000000000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  mode_reg, mode_next;
    logic [4:0]  dly_reg, dly_next;
    logic [15:0] blk_reg, blk_next;
    logic [14:0] wc_reg, wc_next;
    logic [7:0]  sav_reg, sav_next;
    logic [39:0] rb_reg, rb_next;
    logic        ext_reg, ext_next;
    logic [7:0]  cmd_reg, cmd_next, drv_reg, drv_next;
    logic [15:0] feat_reg, feat_next, cnt_reg, cnt_next, sect_reg, sect_next;
    logic [15:0] cyll_reg, cyll_next, cylh_reg, cylh_next, blocks_reg, blocks_next;
    logic [14:0] wpb_reg, wpb_next;

    logic [15:0] v;
    logic [7:0]  s;
    logic [15:0] blk_inc;
    logic [14:0] wc_inc;
    logic [4:0]  didx;
    logic [4:0]  dinc;
    logic [7:0]  code;
    res_t        end_rd;

    assign v       = din[144:129];
    assign s       = v[7:0];
    assign blk_inc = blk_reg + 16'd1;
    assign wc_inc  = wc_reg + 15'd1;
    assign code    = sav_reg & ST_EMASK;
    assign didx    = (dly_reg > 5'd4) ? 5'd4 : dly_reg;
    assign dinc    = didx + 5'd1;
    assign end_rd  = (blk_inc < blocks_reg) ? mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0)
                                             : mk_res(KIND_RD, 1'b0, 3'd1, '0, 1'b0, '0, 1'b0);

    always_comb begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        dly_next    = dly_reg;
        blk_next    = blk_reg;
        wc_next     = wc_reg;
        sav_next    = sav_reg;
        rb_next     = rb_reg;
        ext_next    = ext_reg;
        cmd_next    = cmd_reg;
        drv_next    = drv_reg;
        feat_next   = feat_reg;
        cnt_next    = cnt_reg;
        sect_next   = sect_reg;
        cyll_next   = cyll_reg;
        cylh_next   = cylh_reg;
        blocks_next = blocks_reg;
        wpb_next    = wpb_reg;
        push        = 1'b0;
        desc        = '0;
        desc.ext    = ext_reg;
        desc.drive  = drv_reg;
        desc.cmd    = cmd_reg;
        desc.feat   = feat_reg;
        desc.count  = cnt_reg;
        desc.sect   = sect_reg;
        desc.cyll   = cyll_reg;
        desc.cylh   = cylh_reg;
        desc.rb     = rb_reg;
        if (accept) begin
            case (op)
                OP_RESET, OP_NODATA, OP_PIOIN, OP_PIOOUT: begin
                    if (phase_reg == PH_IDLE) begin
                        rb_next = '0;
                        push    = 1'b1;
                        if (op == OP_RESET) begin
                            desc.two   = 1'b1;
                            desc.r0    = mk_res(KIND_WR, 1'b1, 3'd0, {8'd0, CTL_SRST},
                                                1'b0, '0, 1'b0);
                            desc.r1    = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                            phase_next = PH_RST_FIRST;
                        end else begin
                            ext_next    = din[0];
                            cmd_next    = din[8:1];
                            feat_next   = din[24:9];
                            cnt_next    = din[40:25];
                            sect_next   = din[56:41];
                            cyll_next   = din[72:57];
                            cylh_next   = din[88:73];
                            drv_next    = din[96:89];
                            wpb_next    = din[111:97];
                            blocks_next = din[128:113];
                            mode_next   = op[1:0];
                            blk_next    = '0;
                            wc_next     = '0;
                            dly_next    = '0;
                            desc.r0     = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
                            phase_next  = PH_CMD_BSY1;
                        end
                    end
                end
                OP_RESP: begin
                    push = 1'b1;
                    unique case (phase_reg)
                        PH_RST_FIRST: begin
                            desc.two   = 1'b1;
                            desc.r0    = mk_res(KIND_WR, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                            desc.r1    = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                            dly_next   = 5'd1;
                            phase_next = PH_RST_SETTLE;
                        end
                        PH_RST_SETTLE: begin
                            if (dly_reg < SETTLE_N) dly_next = dly_reg + 5'd1;
                            else phase_next = PH_RST_CHECK;
                            desc.r0 = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                        end
                        PH_RST_CHECK: begin
                            sav_next = s;
                            if (s == NO_BUS) begin
                                desc.r0    = mk_res(KIND_DONE, 1'b0, 3'd0, '0, 1'b0, 8'd1, 1'b1);
                                phase_next = PH_IDLE;
                            end else begin
                                desc.r0    = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                                phase_next = PH_RST_POLL;
                            end
                        end
                        PH_RST_POLL: begin
                            sav_next = s;
                            if ((s & ST_BSY) != 8'd0) begin
                                desc.r0 = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                            end else begin
                                desc.r0    = mk_res(KIND_DONE, 1'b0, 3'd0, '0, 1'b0, 8'd0, 1'b1);
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_CMD_BSY1: begin
                            sav_next = s;
                            if ((s & ST_BSY) != 8'd0) begin
                                desc.r0 = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
                            end else begin
                                desc.r0    = mk_res(KIND_RD, 1'b0, 3'd6, '0, 1'b0, '0, 1'b0);
                                phase_next = PH_CMD_DRV;
                            end
                        end
                        PH_CMD_DRV: begin
                            if ((s & DRV_SLV) != (drv_reg & DRV_SLV)) begin
                                desc.two   = 1'b1;
                                desc.r0    = mk_res(KIND_WR, 1'b0, 3'd6, {8'd0, drv_reg},
                                                    1'b0, '0, 1'b0);
                                desc.r1    = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                                dly_next   = 5'd1;
                                phase_next = PH_CMD_SEL;
                            end else begin
                                desc.tf    = 1'b1;
                                phase_next = PH_CMD_BSY2;
                            end
                        end
                        PH_CMD_SEL: begin
                            if (dly_reg < 5'd4) begin
                                dly_next = dly_reg + 5'd1;
                                desc.r0  = mk_res(KIND_RD, 1'b1, 3'd0, '0, 1'b0, '0, 1'b0);
                            end else begin
                                desc.tf    = 1'b1;
                                phase_next = PH_CMD_BSY2;
                            end
                        end
                        PH_CMD_BSY2: begin
                            sav_next = s;
                            if ((s & ST_BSY) != 8'd0) begin
                                desc.r0 = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
                            end else begin
                                dly_next   = '0;
                                desc.r0    = mk_res(KIND_RD, 1'b0, 3'd1, '0, 1'b0, '0, 1'b0);
                                phase_next = PH_READBACK;
                            end
                        end
                        PH_READBACK: begin
                            rb_next[didx[2:0]*8 +: 8] = s;
                            desc.rb  = rb_next;
                            dly_next = dinc;
                            if (dinc < 5'd5) begin
                                desc.r0 = mk_res(KIND_RD, 1'b0, 3'(dinc + 5'd1), '0, 1'b0,
                                                 '0, 1'b0);
                            end else if (mode_reg == MODE_NODATA || code != 8'd0) begin
                                desc.r0    = mk_res(KIND_DONE, 1'b0, 3'd0, '0, 1'b0, code, 1'b1);
                                phase_next = PH_IDLE;
                            end else begin
                                blk_next   = '0;
                                wc_next    = '0;
                                desc.r0    = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
                                phase_next = PH_DPOLL;
                            end
                        end
                        PH_DPOLL: begin
                            if (mode_reg == MODE_PIOIN) begin
                                if ((s & ST_EMASK) != 8'd0) begin
                                    desc.r0    = mk_res(KIND_RD, 1'b0, 3'd1, '0, 1'b0, '0, 1'b0);
                                    phase_next = PH_FIN;
                                end else if ((s & ST_BSY) != 8'd0) begin
                                    desc.r0 = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
                                end else begin
                                    wc_next    = '0;
                                    desc.r0    = mk_res(KIND_RD, 1'b0, 3'd0, '0, 1'b1, '0, 1'b0);
                                    phase_next = PH_DIN;
                                end
                            end else begin
                                if ((s & ST_ERR) != 8'd0) begin
                                    desc.r0    = mk_res(KIND_RD, 1'b0, 3'd1, '0, 1'b0, '0, 1'b0);
                                    phase_next = PH_FIN;
                                end else if ((s & ST_DRQ) != 8'd0) begin
                                    wc_next    = '0;
                                    desc.r0    = mk_res(KIND_READY, 1'b0, 3'd0, '0, 1'b0, '0,
                                                        1'b0);
                                    phase_next = PH_DOUT;
                                end else begin
                                    desc.r0 = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
                                end
                            end
                        end
                        PH_DIN: begin
                            desc.two = 1'b1;
                            desc.r0  = mk_res(KIND_HOST, 1'b0, 3'd0, v, 1'b1, '0, 1'b0);
                            wc_next  = wc_inc;
                            if (wc_inc == wpb_reg) begin
                                blk_next   = blk_inc;
                                wc_next    = '0;
                                desc.r1    = end_rd;
                                phase_next = (blk_inc < blocks_reg) ? PH_DPOLL : PH_FIN;
                            end else begin
                                desc.r1 = mk_res(KIND_RD, 1'b0, 3'd0, '0, 1'b1, '0, 1'b0);
                            end
                        end
                        PH_FIN: begin
                            desc.r0    = mk_res(KIND_DONE, 1'b0, 3'd0, '0, 1'b0, s, 1'b1);
                            phase_next = PH_IDLE;
                        end
                        default: push = 1'b0;
                    endcase
                end
                OP_DATA: begin
                    if (phase_reg == PH_DOUT) begin
                        push    = 1'b1;
                        desc.r0 = mk_res(KIND_WR, 1'b0, 3'd0, v, 1'b1, '0, 1'b0);
                        wc_next = wc_inc;
                        if (wc_inc == wpb_reg) begin
                            desc.two   = 1'b1;
                            blk_next   = blk_inc;
                            wc_next    = '0;
                            desc.r1    = end_rd;
                            phase_next = (blk_inc < blocks_reg) ? PH_DPOLL : PH_FIN;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            mode_reg   <= '0;
            dly_reg    <= '0;
            blk_reg    <= '0;
            wc_reg     <= '0;
            sav_reg    <= '0;
            rb_reg     <= '0;
            ext_reg    <= '0;
            cmd_reg    <= '0;
            drv_reg    <= '0;
            feat_reg   <= '0;
            cnt_reg    <= '0;
            sect_reg   <= '0;
            cyll_reg   <= '0;
            cylh_reg   <= '0;
            blocks_reg <= '0;
            wpb_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            dly_reg    <= dly_next;
            blk_reg    <= blk_next;
            wc_reg     <= wc_next;
            sav_reg    <= sav_next;
            rb_reg     <= rb_next;
            ext_reg    <= ext_next;
            cmd_reg    <= cmd_next;
            drv_reg    <= drv_next;
            feat_reg   <= feat_next;
            cnt_reg    <= cnt_next;
            sect_reg   <= sect_next;
            cyll_reg   <= cyll_next;
            cylh_reg   <= cylh_next;
            blocks_reg <= blocks_next;
            wpb_reg    <= wpb_next;
        end
    end

endmodule

[hw/rtl/acps_queue.sv]
// Two-entry descriptor queue between front and back of the command sequencer.
// Depends on acps_pkg.
module acps_queue
    import acps_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  q_ctl_t ctl_in,
    input  desc_t  wdata,
    output desc_t  rdata,
    output logic   full,
    output logic   avail
);

    desc_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl_in.push && !ctl_in.pop) cnt_next = cnt_reg + 2'd1;
        else if (!ctl_in.push && ctl_in.pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.push) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (ctl_in.push) wp_reg <= ~wp_reg;
            if (ctl_in.pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/acps_back.sv]
// Back end of the command sequencer: expands descriptors into bus results.
// Depends on acps_pkg. Drives the registered result channel.
module acps_back
    import acps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_avail,
    input  desc_t       q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res,
    output logic [39:0] m_rb,
    output logic        m_last
);

    desc_t       cur_reg;
    logic        busy_reg;
    logic [3:0]  step_reg;
    logic        val_reg;
    res_t        res_reg;
    logic [39:0] rb_reg;
    logic        last_reg;

    desc_t       d;
    logic [3:0]  step;
    logic [3:0]  len;
    logic [3:0]  k;
    res_t        r;
    logic        adv;
    logic        go;
    logic [15:0] tv;

    assign adv  = !val_reg || m_ready;
    assign d    = busy_reg ? cur_reg : q_head;
    assign step = busy_reg ? step_reg : 4'd0;
    assign go   = adv && (busy_reg || q_avail);
    assign q_pop = adv && !busy_reg && q_avail;
    assign len  = d.tf ? (d.ext ? 4'd13 : 4'd8) : (d.two ? 4'd2 : 4'd1);
    assign k    = (d.ext && step > 4'd5) ? step - 4'd5 : step;

    always_comb begin
        case (k[2:0])
            3'd1:    tv = d.feat;
            3'd2:    tv = d.count;
            3'd3:    tv = d.sect;
            3'd4:    tv = d.cyll;
            default: tv = d.cylh;
        endcase
        if (!d.tf) begin
            r = (step == 4'd0) ? d.r0 : d.r1;
        end else if (step == 4'd0) begin
            r = mk_res(KIND_WR, 1'b0, 3'd6, {8'd0, d.drive}, 1'b0, '0, 1'b0);
        end else if (d.ext && step <= 4'd5) begin
            r = mk_res(KIND_WR, 1'b0, step[2:0], {8'd0, tv[15:8]}, 1'b0, '0, 1'b0);
        end else if (k <= 4'd5) begin
            r = mk_res(KIND_WR, 1'b0, k[2:0], {8'd0, tv[7:0]}, 1'b0, '0, 1'b0);
        end else if (k == 4'd6) begin
            r = mk_res(KIND_WR, 1'b0, 3'd7, {8'd0, d.cmd}, 1'b0, '0, 1'b0);
        end else begin
            r = mk_res(KIND_RD, 1'b0, 3'd7, '0, 1'b0, '0, 1'b0);
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            res_reg  <= r;
            rb_reg   <= r.back ? d.rb : 40'd0;
            last_reg <= (step == len - 4'd1);
            step_reg <= step + 4'd1;
        end
        if (q_pop) cur_reg <= q_head;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            val_reg  <= 1'b0;
        end else begin
            if (adv) val_reg <= go;
            if (go) busy_reg <= (step != len - 4'd1);
        end
    end

    assign m_valid = val_reg;
    assign m_res   = res_reg;
    assign m_rb    = rb_reg;
    assign m_last  = last_reg;

endmodule

[hw/rtl/ata_pio_command_sequencer.sv]
// Top level of the ATA PIO task-file command sequencer.
// Depends on acps_pkg, acps_front, acps_queue and acps_back.
//
// Each item is classified in the cycle it is accepted; its results, one to thirteen,
// leave one per cycle from a registered output unless m_tready stalls it. The input
// takes an item every cycle while the two-entry descriptor queue has room, so a stalled
// output holds the input only once two items wait in the queue behind the one being
// unloaded; an extended task-file load is twelve writes and a status read, thirteen results.
module ata_pio_command_sequencer
    import acps_pkg::*;
#(
    parameter int RESET_SETTLE_READS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // extended, command_code, features_value, sector_count, sector_number,
    // cyl_low_value, cyl_high_value, drive_select, words_per_block, block_count, bus_data
    input  logic [151:0] s_tdata,
    // opcode
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_select, reg_offset, write_data, is_word, return_code, back_error,
    // back_count, back_sector, back_cyl_low, back_cyl_high
    output logic [71:0]  m_tdata,
    // kind
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    logic        accept, push, full, avail, pop;
    desc_t       wdesc, hdesc;
    q_ctl_t      qc;
    res_t        res;
    logic [39:0] rb;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign qc       = '{push: push, pop: pop, full: full, avail: avail};

    acps_front #(.SETTLE(RESET_SETTLE_READS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .accept(accept), .op(s_tuser),
        .din(s_tdata), .push(push), .desc(wdesc)
    );

    acps_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(qc), .wdata(wdesc),
        .rdata(hdesc), .full(full), .avail(avail)
    );

    acps_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_avail(avail), .q_head(hdesc), .q_pop(pop),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res), .m_rb(rb), .m_last(m_tlast)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {3'd0, rb[39:32], rb[31:24], rb[23:16], rb[15:8], rb[7:0],
                      res.rc, res.word, res.data, res.off, res.blk};

    a_back_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_DONE |-> m_tdata[68:21] == 48'd0)
        else $error("read-back or code on a non-completion result");

    a_host_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_HOST |-> m_tdata[20])
        else $error("host data word without word flag");

    a_ready_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_READY || m_tuser == KIND_DONE) |-> m_tlast)
        else $error("ready or completion not last");

endmodule

[tb/acps_checker.sv]
// Result checker for the ATA PIO command sequencer: tracks the task-file protocol
// from accepted input words and compares every result word in order.
// Depends on acps_pkg.
module acps_checker
    import acps_pkg::*;
#(
    parameter int RESET_SETTLE_READS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_RST_FIRST, SQ_RST_SETTLE, SQ_RST_CHECK, SQ_RST_POLL,
        SQ_CMD_BSY1, SQ_CMD_DRV, SQ_CMD_SEL, SQ_CMD_BSY2, SQ_READBACK,
        SQ_DPOLL, SQ_DIN, SQ_DOUT, SQ_FIN
    } seq_phase_e;

    // {kind, tdata, last}
    typedef logic [75:0] bus_word_t;

    seq_phase_e  ph;
    logic [15:0] l_feat, l_count, l_sect, l_cyll, l_cylh, l_blocks;
    logic [7:0]  l_drive, l_cmd;
    logic [14:0] l_wpb;
    logic        l_ext;
    logic [1:0]  mode;
    logic [4:0]  dly;
    logic [15:0] blk_cnt;
    logic [14:0] wrd_cnt;
    logic [7:0]  sav_st;
    logic [7:0]  rb [5];
    bus_word_t   due_results [$];
    int          n_new;

    function automatic void emit(logic [2:0] kind, logic blk, logic [2:0] off,
                                 logic [15:0] data, logic word, logic [7:0] rc,
                                 logic back);
        logic [71:0] td;
        td = {3'b0, back ? rb[4] : 8'h0, back ? rb[3] : 8'h0, back ? rb[2] : 8'h0,
              back ? rb[1] : 8'h0, back ? rb[0] : 8'h0, rc, word, data, off, blk};
        due_results.push_back({kind, td, 1'b0});
        n_new++;
    endfunction

    function automatic void bus_rd(logic blk, logic [2:0] off);
        emit(KIND_RD, blk, off, 16'h0, 1'b0, 8'h0, 1'b0);
    endfunction

    function automatic void bus_wr(logic blk, logic [2:0] off, logic [7:0] v);
        emit(KIND_WR, blk, off, {8'h0, v}, 1'b0, 8'h0, 1'b0);
    endfunction

    function automatic void complete(logic [7:0] rc);
        emit(KIND_DONE, 1'b0, 3'd0, 16'h0, 1'b0, rc, 1'b1);
        ph = SQ_IDLE;
    endfunction

    function automatic void load_task_file();
        bus_wr(1'b0, 3'd6, l_drive);
        if (l_ext) begin
            bus_wr(1'b0, 3'd1, l_feat[15:8]);
            bus_wr(1'b0, 3'd2, l_count[15:8]);
            bus_wr(1'b0, 3'd3, l_sect[15:8]);
            bus_wr(1'b0, 3'd4, l_cyll[15:8]);
            bus_wr(1'b0, 3'd5, l_cylh[15:8]);
        end
        bus_wr(1'b0, 3'd1, l_feat[7:0]);
        bus_wr(1'b0, 3'd2, l_count[7:0]);
        bus_wr(1'b0, 3'd3, l_sect[7:0]);
        bus_wr(1'b0, 3'd4, l_cyll[7:0]);
        bus_wr(1'b0, 3'd5, l_cylh[7:0]);
        bus_wr(1'b0, 3'd7, l_cmd);
        bus_rd(1'b0, 3'd7);
        ph = SQ_CMD_BSY2;
    endfunction

    function automatic void next_block();
        blk_cnt++;
        wrd_cnt = '0;
        if (blk_cnt < l_blocks) begin
            bus_rd(1'b0, 3'd7);
            ph = SQ_DPOLL;
        end else begin
            bus_rd(1'b0, 3'd1);
            ph = SQ_FIN;
        end
    endfunction

    function automatic void take_response(logic [15:0] v);
        logic [7:0] s;
        logic [7:0] code;
        s = v[7:0];
        case (ph)
            SQ_RST_FIRST: begin
                bus_wr(1'b1, 3'd0, 8'h00);
                bus_rd(1'b1, 3'd0);
                dly = 5'd1;
                ph = SQ_RST_SETTLE;
            end
            SQ_RST_SETTLE: begin
                if (dly < RESET_SETTLE_READS) dly++;
                else ph = SQ_RST_CHECK;
                bus_rd(1'b1, 3'd0);
            end
            SQ_RST_CHECK: begin
                sav_st = s;
                if (s == NO_BUS) begin
                    complete(8'd1);
                end else begin
                    bus_rd(1'b1, 3'd0);
                    ph = SQ_RST_POLL;
                end
            end
            SQ_RST_POLL: begin
                sav_st = s;
                if (s & ST_BSY) bus_rd(1'b1, 3'd0);
                else complete(8'd0);
            end
            SQ_CMD_BSY1: begin
                sav_st = s;
                if (s & ST_BSY) begin
                    bus_rd(1'b0, 3'd7);
                end else begin
                    bus_rd(1'b0, 3'd6);
                    ph = SQ_CMD_DRV;
                end
            end
            SQ_CMD_DRV: begin
                if ((s & DRV_SLV) != (l_drive & DRV_SLV)) begin
                    bus_wr(1'b0, 3'd6, l_drive);
                    bus_rd(1'b1, 3'd0);
                    dly = 5'd1;
                    ph = SQ_CMD_SEL;
                end else begin
                    load_task_file();
                end
            end
            SQ_CMD_SEL: begin
                if (dly < 5'd4) begin
                    dly++;
                    bus_rd(1'b1, 3'd0);
                end else begin
                    load_task_file();
                end
            end
            SQ_CMD_BSY2: begin
                sav_st = s;
                if (s & ST_BSY) begin
                    bus_rd(1'b0, 3'd7);
                end else begin
                    dly = 5'd0;
                    bus_rd(1'b0, 3'd1);
                    ph = SQ_READBACK;
                end
            end
            SQ_READBACK: begin
                if (dly > 5'd4) dly = 5'd4;
                rb[dly] = s;
                dly++;
                if (dly < 5'd5) begin
                    bus_rd(1'b0, 3'(dly + 5'd1));
                end else begin
                    code = sav_st & ST_EMASK;
                    if (mode == MODE_NODATA || code != 8'h0) begin
                        complete(code);
                    end else begin
                        blk_cnt = '0;
                        wrd_cnt = '0;
                        bus_rd(1'b0, 3'd7);
                        ph = SQ_DPOLL;
                    end
                end
            end
            SQ_DPOLL: begin
                if (mode == MODE_PIOIN) begin
                    if (s & ST_EMASK) begin
                        bus_rd(1'b0, 3'd1);
                        ph = SQ_FIN;
                    end else if (s & ST_BSY) begin
                        bus_rd(1'b0, 3'd7);
                    end else begin
                        wrd_cnt = '0;
                        emit(KIND_RD, 1'b0, 3'd0, 16'h0, 1'b1, 8'h0, 1'b0);
                        ph = SQ_DIN;
                    end
                end else begin
                    if (s & ST_ERR) begin
                        bus_rd(1'b0, 3'd1);
                        ph = SQ_FIN;
                    end else if (s & ST_DRQ) begin
                        wrd_cnt = '0;
                        emit(KIND_READY, 1'b0, 3'd0, 16'h0, 1'b0, 8'h0, 1'b0);
                        ph = SQ_DOUT;
                    end else begin
                        bus_rd(1'b0, 3'd7);
                    end
                end
            end
            SQ_DIN: begin
                emit(KIND_HOST, 1'b0, 3'd0, v, 1'b1, 8'h0, 1'b0);
                wrd_cnt++;
                if (wrd_cnt == l_wpb) next_block();
                else emit(KIND_RD, 1'b0, 3'd0, 16'h0, 1'b1, 8'h0, 1'b0);
            end
            SQ_FIN: complete(s);
            default: ;
        endcase
    endfunction

    function automatic void predict(logic [2:0] op, logic [151:0] d);
        n_new = 0;
        if (op <= OP_PIOOUT) begin
            if (ph == SQ_IDLE) begin
                foreach (rb[i]) rb[i] = 8'h0;
                if (op == OP_RESET) begin
                    bus_wr(1'b1, 3'd0, CTL_SRST);
                    bus_rd(1'b1, 3'd0);
                    ph = SQ_RST_FIRST;
                end else begin
                    l_ext    = d[0];
                    l_cmd    = d[8:1];
                    l_feat   = d[24:9];
                    l_count  = d[40:25];
                    l_sect   = d[56:41];
                    l_cyll   = d[72:57];
                    l_cylh   = d[88:73];
                    l_drive  = d[96:89];
                    l_wpb    = d[111:97];
                    l_blocks = d[128:113];
                    mode     = op[1:0];
                    blk_cnt  = '0;
                    wrd_cnt  = '0;
                    dly      = '0;
                    bus_rd(1'b0, 3'd7);
                    ph = SQ_CMD_BSY1;
                end
            end
        end else if (op == OP_RESP) begin
            if (ph != SQ_IDLE && ph != SQ_DOUT) take_response(d[144:129]);
        end else if (op == OP_DATA) begin
            if (ph == SQ_DOUT) begin
                emit(KIND_WR, 1'b0, 3'd0, d[144:129], 1'b1, 8'h0, 1'b0);
                wrd_cnt++;
                if (wrd_cnt == l_wpb) next_block();
            end
        end
        if (n_new > 0) due_results[$][0] = 1'b1;
    endfunction

    always @(posedge aclk) begin
        bus_word_t want;
        bus_word_t got;
        if (!aresetn) begin
            ph = SQ_IDLE;
            {l_feat, l_count, l_sect, l_cyll, l_cylh, l_blocks} = '0;
            {l_drive, l_cmd, l_wpb, l_ext, mode, dly, blk_cnt, wrd_cnt, sav_st} = '0;
            foreach (rb[i]) rb[i] = 8'h0;
            due_results.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata, m_tlast};
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: kind %0d data %h last %b",
                                 m_tuser, m_tdata, m_tlast);
                end else begin
                    want = due_results.pop_front();
                    if (want[75:73] !== got[75:73] || want[72:1] !== got[72:1]
                            || want[0] !== got[0]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: kind %0d/%0d data %h/%h last %b/%b (exp/act)",
                                     want[75:73], got[75:73], want[72:1], got[72:1],
                                     want[0], got[0]);
                    end
                end
            end
        end
        pending = due_results.size();
    end

endmodule

[tb/tb.sv]
// Stimulus and verdict for the ATA PIO command sequencer: runs reset, non-data,
// PIO-in and PIO-out sequences while answering bus reads. Depends on acps_pkg,
// ata_pio_command_sequencer and acps_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acps_pkg::*;

    localparam int LIMIT = 3000000;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    int           fail_count;
    int           pending;

    int           idle_pct;
    int           stall_pct;
    int           cycles;
    int           items_sent;
    int           dones_seen;
    int           words_due;
    int           words_sent;
    int           cur_words;
    bit           force_no_bus;
    logic [1:0]   read_kinds [$];   // bit 0 status read, bit 1 data word read

    always #5 aclk = ~aclk;

    ata_pio_command_sequencer i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    acps_checker i_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast, .fail_count, .pending
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tuser)
                KIND_RD: read_kinds.push_back({m_tdata[20],
                         (m_tdata[3:0] == {3'd7, 1'b0}) || (m_tdata[3:0] == {3'd0, 1'b1})});
                KIND_READY: words_due += cur_words;
                KIND_DONE: dones_seen++;
                default: ;
            endcase
        end
    end

    function automatic logic [151:0] random_vec();
        logic [159:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return {7'b0, r[144:0]};
    endfunction

    function automatic logic [151:0] pack_item(logic ext, logic [7:0] cmd, logic [15:0] feat,
                                               logic [15:0] cnt, logic [15:0] sec,
                                               logic [15:0] cl, logic [15:0] ch,
                                               logic [7:0] drv, logic [15:0] wpb,
                                               logic [15:0] blocks);
        return {7'b0, 16'($urandom), blocks, wpb, drv, ch, cl, sec, cnt, feat, cmd, ext};
    endfunction

    function automatic logic [7:0] status_byte();
        int r;
        logic [7:0] x;
        r = $urandom_range(0, 99);
        x = 8'($urandom);
        if (force_no_bus) return NO_BUS;
        if (r < 15) return ST_BSY | x;
        if (r < 20) return (x & 8'h7F) | (r[0] ? ST_ERR : 8'h20);
        if (r < 23) return NO_BUS;
        if (r < 35) return x & 8'h56;
        return ST_DRQ | (x & 8'h56);
    endfunction

    task automatic idle_cycle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(logic [2:0] op, logic [151:0] d);
        while ($urandom_range(0, 99) < idle_pct) idle_cycle();
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        idle_cycle();
        while (pending != 0) idle_cycle();
    endtask

    task automatic run_sequence(logic [2:0] op, logic [151:0] d);
        int start_done;
        logic [1:0] rk;
        logic [151:0] r;
        read_kinds.delete();
        words_sent = words_due;
        cur_words  = (d[111:97] == 15'd0) ? 32768 : int'(d[111:97]);
        start_done = dones_seen;
        send_word(op, d);
        if ($urandom_range(0, 2) == 0) send_word(3'($urandom_range(0, 3)), random_vec());
        while (dones_seen == start_done) begin
            r = random_vec();
            if (read_kinds.size() > 0) begin
                rk = read_kinds.pop_front();
                if (rk[0] && !rk[1]) r[136:129] = status_byte();
                send_word(OP_RESP, r);
            end else if (words_sent != words_due) begin
                send_word(OP_DATA, r);
                words_sent++;
            end else if ($urandom_range(0, 19) == 0) begin
                send_word(3'($urandom_range(6, 7)), r);
            end else begin
                idle_cycle();
            end
        end
    endtask

    task automatic random_sequence();
        int r;
        logic [2:0] op;
        logic [151:0] d;
        r = $urandom_range(0, 99);
        op = (r < 10) ? OP_RESET : (r < 35) ? OP_NODATA : (r < 70) ? OP_PIOIN : OP_PIOOUT;
        d = pack_item(1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                      {1'($urandom), 15'($urandom_range(1, 4))},
                      16'($urandom_range(0, 3)));
        run_sequence(op, d);
    endtask

    initial begin
        int quota;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        m_tready     <= 1'b0;
        aresetn      <= 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        force_no_bus = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_sequence(OP_RESET, random_vec());
        force_no_bus = 1'b1;
        run_sequence(OP_RESET, random_vec());
        force_no_bus = 1'b0;
        run_sequence(OP_NODATA, pack_item(1'b0, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                                          8'h00, 16'h1, 16'h1));
        run_sequence(OP_NODATA, pack_item(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        run_sequence(OP_PIOIN, pack_item(1'b1, 8'h24, 16'h1234, 16'h0002, 16'h5678,
                                         16'h9ABC, 16'hDEF0, 8'hE0, 16'd2, 16'd2));
        run_sequence(OP_PIOIN, pack_item(1'b0, 8'h20, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0,
                                         8'hF0, 16'h8001, 16'd0));
        run_sequence(OP_PIOOUT, pack_item(1'b0, 8'h30, 16'h0, 16'h2, 16'h0, 16'h0, 16'h0,
                                          8'hA0, 16'd3, 16'd2));
        run_sequence(OP_PIOOUT, pack_item(1'b1, 8'h34, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0,
                                          8'hB0, 16'h8003, 16'd1));
        // stray words while idle
        send_word(OP_RESP, random_vec());
        send_word(OP_DATA, random_vec());
        send_word(3'd6, random_vec());
        send_word(3'd7, random_vec());
        wait_drained();

        items_sent = 0;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            quota = 93 * (p + 1);
            while (items_sent < quota) begin
                random_sequence();
                if ($urandom_range(0, 3) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (30) idle_cycle();
        if (fail_count == 0 && pending == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

endmodule
